### hw/rtl/murmur3_32_stream_hash_defines.svh
// Assertion macros for the MurmurHash3 stream hash block.
// Included by files that check their own logic; depends on nothing else.
`ifndef MURMUR3_32_STREAM_HASH_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define M3H_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3h: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define M3H_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m3h: next-cycle check failed");

`endif

### hw/rtl/m3h_pkg.sv
// Shared constants, command and status types and mixing helpers for the hash block.
// Used by the controller, the datapath and the top level; depends on nothing.
package m3h_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    typedef struct packed {
        logic load;
        logic mix2;
        logic absorb;
        logic fin1;
        logic fin2;
        logic fin3;
    } m3h_cmd_t;

    typedef struct packed {
        logic last;
    } m3h_sts_t;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        begin
            p = {32'd0, a} * {32'd0, b};
            return p[31:0];
        end
    endfunction

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

endpackage

### hw/rtl/m3h_ctrl.sv
// Sequencing state machine for the hash block: input handshake, step commands, output valid.
// Depends on m3h_pkg.
module m3h_ctrl
    import m3h_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  m3h_sts_t  sts,
    output m3h_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MIX2 = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_FIN1 = 3'd3;
    localparam logic [2:0] S_FIN2 = 3'd4;
    localparam logic [2:0] S_FIN3 = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MIX2;
                end
            end
            S_MIX2:
            begin
                cmd.mix2   = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.absorb = 1'b1;
                state_next = sts.last ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                if (out_free)
                begin
                    cmd.fin3   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.fin3)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/m3h_dp.sv
// Datapath for the hash block: block scramble, running hash, byte count and fmix32 stages.
// Depends on m3h_pkg; driven by commands from m3h_ctrl.
module m3h_dp
    import m3h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  m3h_cmd_t    cmd,
    output m3h_sts_t    sts,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic [31:0] hash_value
);

    logic [31:0] k_reg;
    logic [31:0] k_next;
    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] t_reg;
    logic [31:0] t_next;
    logic [31:0] f_reg;
    logic [31:0] f_next;
    logic [31:0] hv_reg;
    logic [31:0] hv_next;
    logic        last_reg;
    logic        last_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;

    logic [2:0]  cnt_sat;
    logic [2:0]  cnt_eff;
    logic [31:0] mask;
    logic [31:0] h_rot;
    logic [31:0] fin_x;

    assign sts.last   = last_reg;
    assign hash_value = hv_reg;

    always_comb
    begin
        cnt_sat = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
        cnt_eff = last_word ? cnt_sat : FULL_BYTES;
        unique case (cnt_eff)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
        h_rot = rotl13(h_reg ^ k_reg);
        fin_x = h_reg ^ t_reg;
    end

    always_comb
    begin
        k_next    = k_reg;
        h_next    = h_reg;
        t_next    = t_reg;
        f_next    = f_reg;
        hv_next   = hv_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            k_next    = mul32(data_word & mask, MIX_C1);
            last_next = last_word;
            cnt_next  = cnt_eff;
        end
        if (cmd.mix2)
        begin
            k_next = mul32(rotl15(k_reg), MIX_C2);
        end
        if (cmd.absorb)
        begin
            priority if (cnt_reg == FULL_BYTES)
            begin
                h_next = {h_rot[29:0], 2'b00} + h_rot + MIX_ADD;
            end
            else if (cnt_reg != 3'd0)
            begin
                h_next = h_reg ^ k_reg;
            end
            else
            begin
                h_next = h_reg;
            end
            t_next = t_reg + {29'd0, cnt_reg};
        end
        if (cmd.fin1)
        begin
            f_next = mul32(fin_x ^ {16'd0, fin_x[31:16]}, FMIX_C1);
            h_next = '0;
            t_next = '0;
        end
        if (cmd.fin2)
        begin
            f_next = mul32(f_reg ^ {13'd0, f_reg[31:13]}, FMIX_C2);
        end
        if (cmd.fin3)
        begin
            hv_next = f_reg ^ {16'd0, f_reg[31:16]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= '0;
            t_reg    <= '0;
            last_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            h_reg    <= h_next;
            t_reg    <= t_next;
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg  <= k_next;
        f_reg  <= f_next;
        hv_reg <= hv_next;
    end

endmodule

### hw/rtl/murmur3_32_stream_hash.sv
// Top level of the MurmurHash3 x86_32 stream hash (seed 0): controller, datapath, checks.
// Depends on m3h_pkg, m3h_ctrl, m3h_dp and murmur3_32_stream_hash_defines.svh.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one beat per 32-bit message word,
//   first byte in bits 7:0. last_word marks the final beat; valid_bytes (0 to 4, larger
//   values count as 4) gives its byte count and is ignored on other beats.
//   The output channel (out_valid / out_stall) carries one beat, hash_value, per message.
//   Each word runs through the same multiply chain: one multiplier stage per cycle.
//   A word that is not last occupies the block through its load, second-multiply and
//   absorb steps, and no new word is taken until they are done. A last word then also
//   runs the two fmix32 multiply stages and the output stage before the next word can
//   be taken.
//   The result sits in an output register, so a new message can start while it waits.
//   If the receiver stalls, the result holds; a following message stops only at its own
//   final stage until the earlier result has been taken.
//   Reset (rst_n low, asynchronous) clears the running hash and byte count to zero and
//   drops out_valid; the first word may be offered right after reset is released.
`include "murmur3_32_stream_hash_defines.svh"

module murmur3_32_stream_hash
    import m3h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    m3h_cmd_t cmd;
    m3h_sts_t sts;

    m3h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    m3h_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .hash_value  (hash_value)
    );

    `M3H_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `M3H_ASSERT_SAME(a_one_step, 1'b1, $onehot0(cmd))
    `M3H_ASSERT_SAME(a_result_from_final, $rose(out_valid), $past(cmd.fin3))
    `M3H_ASSERT_SAME(a_load_only_idle, cmd.load, !in_stall && in_valid)

endmodule

### tb/murmur3_32_stream_hash_chk.sv
`timescale 1ns / 1ps
// Scoreboard for murmur3_32_stream_hash: follows both channels, keeps its own MurmurHash3
// x86_32 (seed 0) state and compares every hash_value beat. Depends only on its ports.
module murmur3_32_stream_hash_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] hash_value,
    output int unsigned mismatches,
    output int unsigned hashes_pending
);

    localparam logic [31:0] KEY_MUL1   = 32'hcc9e2d51;
    localparam logic [31:0] KEY_MUL2   = 32'h1b873593;
    localparam logic [31:0] HASH_ADD   = 32'he6546b64;
    localparam logic [31:0] FINAL_MUL1 = 32'h85ebca6b;
    localparam logic [31:0] FINAL_MUL2 = 32'hc2b2ae35;
    localparam logic [2:0]  WORD_BYTES = 3'd4;

    logic [31:0] acc_hash;
    logic [31:0] acc_bytes;
    logic [31:0] want_hash;
    logic [31:0] expected_hashes[$];

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] scramble_key(input logic [31:0] k);
        logic [31:0] t;
        t = k * KEY_MUL1;
        t = rotl32(t, 15);
        t = t * KEY_MUL2;
        return t;
    endfunction

    function automatic logic [31:0] fmix32(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FINAL_MUL1;
        t = t ^ (t >> 13);
        t = t * FINAL_MUL2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    task automatic absorb_block(input logic [31:0] k);
        logic [31:0] t;
        t = rotl32(acc_hash ^ scramble_key(k), 13);
        acc_hash = t * 32'd5 + HASH_ADD;
    endtask

    // A word that is not last is always a full block; the byte count matters only on
    // the last word, where counts above four are taken as four.
    task automatic take_word(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last);
        logic [2:0]  cnt;
        logic [31:0] tail;
        if (!last)
        begin
            absorb_block(word);
            acc_bytes = acc_bytes + 32'd4;
        end
        else
        begin
            cnt = (nbytes > WORD_BYTES) ? WORD_BYTES : nbytes;
            if (cnt == WORD_BYTES)
            begin
                absorb_block(word);
            end
            else if (cnt != 3'd0)
            begin
                tail = word & ((32'd1 << (8 * cnt)) - 32'd1);
                acc_hash = acc_hash ^ scramble_key(tail);
            end
            acc_bytes = acc_bytes + {29'd0, cnt};
            expected_hashes.push_back(fmix32(acc_hash ^ acc_bytes));
            acc_hash  = '0;
            acc_bytes = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_hash   = '0;
            acc_bytes  = '0;
            mismatches = 0;
            expected_hashes.delete();
            hashes_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $error("hash_value: unexpected beat, expected none, actual %08h",
                           hash_value);
                    mismatches++;
                end
                else
                begin
                    want_hash = expected_hashes.pop_front();
                    if (hash_value !== want_hash)
                    begin
                        $error("hash_value: expected %08h, actual %08h", want_hash,
                               hash_value);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                take_word(data_word, valid_bytes, last_word);
            end
            hashes_pending <= expected_hashes.size();
        end
    end

endmodule

### tb/murmur3_32_stream_hash_tb.sv
`timescale 1ns / 1ps
// Testbench top for murmur3_32_stream_hash: drives word streams in random bursts, stalls
// the result channel and gives the verdict. Needs the block and murmur3_32_stream_hash_chk.
module murmur3_32_stream_hash_tb;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    localparam int unsigned WORD_TARGET = 1900;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [31:0] data_word   = '0;
    logic [2:0]  valid_bytes = '0;
    logic        last_word   = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [31:0] hash_value;
    int unsigned mismatches;
    int unsigned hashes_pending;

    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_phase = 0;
    stall_mode_t stall_mode  = STALL_NONE;

    murmur3_32_stream_hash i_dut (.*);

    murmur3_32_stream_hash_chk i_chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL murmur3_32_stream_hash");
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= ((stall_phase % 7) < 3);
        endcase
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid    <= 1'b1;
        data_word   <= word;
        valid_bytes <= nbytes;
        last_word   <= last;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic send_message(input int unsigned body_words, input logic [2:0] tail_bytes);
        repeat (body_words) send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
        send_word(rand_word(), tail_bytes, 1'b1);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned body;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // A lone empty last word must hash to zero even with all data bits set.
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        for (int n = 1; n < 8; n++)
        begin
            send_word(32'hffff_ffff, 3'(n), 1'b1);
        end
        send_word(32'h0000_0000, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b0);
        send_word(32'h0000_0000, 3'd0, 1'b0);
        send_word(32'h8000_0001, 3'd0, 1'b1);
        send_word(32'h1234_5678, 3'd3, 1'b0);
        send_word(32'hdead_beef, 3'd2, 1'b1);
        send_word(32'h0000_0000, 3'd5, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b1);

        while (words_sent < WORD_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                body = $urandom_range(0, 4);
            end
            else if (pick < 9)
            begin
                body = $urandom_range(5, 16);
            end
            else
            begin
                body = $urandom_range(17, 60);
            end
            send_message(body, 3'($urandom_range(0, 7)));
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (hashes_pending != 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS murmur3_32_stream_hash");
        end
        else
        begin
            $display("FAIL murmur3_32_stream_hash");
        end
        $finish;
    end

endmodule
